@@ hdl/mbar_pkg.sv @@
// ----------------------------------------------------------------------------
// mbar_pkg
// Shared constants and the hex digit decoder for the ASCII frame receiver.
// ----------------------------------------------------------------------------
package mbar_pkg;

   localparam int MAX_PDU_CHARS_DEFAULT = 506;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int COUNT_W    = 10;

   localparam logic [7:0] START_CHAR      = 8'h3A;
   localparam logic [7:0] CR_CHAR         = 8'h0D;
   localparam logic [7:0] LF_CHAR         = 8'h0A;
   localparam logic [7:0] ERROR_REPLY_BIT = 8'h80;

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_BODY    = 2'd1;
   localparam logic [1:0] PH_LRC     = 2'd2;
   localparam logic [1:0] PH_TRAILER = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_LRC_ERR = 2'd1;
   localparam logic [1:0] ST_TRAILER = 2'd2;

   typedef struct packed {
      logic [7:0] function_code;
      logic [7:0] slave_address;
      logic [7:0] exception_code;
      logic       is_exception;
      logic [1:0] frame_status;
      logic [7:0] byte_index;
      logic [7:0] data_byte;
   } rsp_fields_type;

   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h41 + 8'd10);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n = 4'(c - 8'h61 + 8'd10);
      end
      return n;
   endfunction

endpackage

@@ hdl/modbus_ascii_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// modbus_ascii_frame_receiver
// Hunts for ':', decodes hex pairs of address and PDU, checks LRC and CR LF.
// Path: a word lands in the input register at acceptance and
//    its result is registered in the rsp register when the state advances.
// Throughput: one character per cycle while the rsp register is free or being taken, set by the single state update.
// Reset: synchronous; both registers empty, receiver hunting for a colon.
// ----------------------------------------------------------------------------
module modbus_ascii_frame_receiver
   import mbar_pkg::*;
#(
   parameter int MAX_PDU_CHARS = MAX_PDU_CHARS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] rx_char, [16:8] expected_pdu_chars, [23:17] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] data_byte, [15:8] byte_index, [17:16] frame_status,
   // [18] is_exception, [26:19] exception_code, [34:27] slave_address,
   // [42:35] function_code, [47:43] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam logic [COUNT_W-1:0] MaxChars = COUNT_W'(MAX_PDU_CHARS);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_char_ff;
   logic [8:0]         in_want_ff;
   logic               advance;

   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] target_ff, target_in;
   logic [3:0]         high_ff, high_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         addr_ff, addr_in;
   logic [7:0]         func_ff, func_in;
   logic [7:0]         exc_ff, exc_in;
   logic [7:0]         lrc_ff, lrc_in;
   logic               cr_ff, cr_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_last_ff, out_last_in;
   rsp_fields_type     out_ff, out_in;
   logic               emit;

   logic [3:0]         nib;
   logic [7:0]         b;
   logic [COUNT_W-1:0] want_sat;
   logic               exc_flag;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata[7:0];
         in_want_ff <= req_tdata[16:8];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      target_in = target_ff;
      high_in = high_ff;
      sum_in = sum_ff;
      addr_in = addr_ff;
      func_in = func_ff;
      exc_in = exc_ff;
      lrc_in = lrc_ff;
      cr_in = cr_ff;
      emit = 1'b0;
      out_last_in = 1'b0;
      out_in = '0;
      nib = hex_nibble(in_char_ff);
      b = {high_ff, nib};
      exc_flag = (func_ff & ERROR_REPLY_BIT) != 8'd0;
      want_sat = {1'b0, in_want_ff};
      if (want_sat < COUNT_W'(2)) begin
         want_sat = COUNT_W'(2);
      end
      if (want_sat > MaxChars) begin
         want_sat = MaxChars;
      end
      case (phase_ff)
         PH_HUNT: begin
            if (in_char_ff == START_CHAR) begin
               target_in = {want_sat[COUNT_W-1:1], 1'b0};
               count_in = '0;
               high_in = '0;
               sum_in = '0;
               addr_in = '0;
               func_in = '0;
               exc_in = '0;
               lrc_in = '0;
               cr_in = 1'b0;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            count_in = count_ff + COUNT_W'(1);
            if (!count_ff[0]) begin
               high_in = nib;
            end else begin
               sum_in = sum_ff + b;
               if (count_ff[8:1] == 8'd0) begin
                  addr_in = b;
               end else if (count_ff[8:1] == 8'd1) begin
                  func_in = b;
                  if ((b & ERROR_REPLY_BIT) != 8'd0) begin
                     target_in = COUNT_W'(4);
                  end
               end else if (count_ff[8:1] == 8'd2 && exc_flag) begin
                  exc_in = b;
               end
               if (count_in >= target_in + COUNT_W'(2)) begin
                  phase_in = PH_LRC;
               end
               emit = 1'b1;
               out_in.data_byte = b;
               out_in.byte_index = count_ff[8:1];
               out_in.slave_address = addr_in;
               out_in.function_code = func_in;
            end
         end
         PH_LRC: begin
            count_in = count_ff + COUNT_W'(1);
            if (!count_ff[0]) begin
               high_in = nib;
            end else begin
               lrc_in = b;
               phase_in = PH_TRAILER;
            end
         end
         default: begin
            if (count_ff == target_ff + COUNT_W'(4)) begin
               cr_in = (in_char_ff == CR_CHAR);
               count_in = count_ff + COUNT_W'(1);
            end else begin
               emit = 1'b1;
               out_last_in = 1'b1;
               if (!cr_ff || in_char_ff != LF_CHAR) begin
                  out_in.frame_status = ST_TRAILER;
               end else if (8'(8'd0 - sum_ff) != lrc_ff) begin
                  out_in.frame_status = ST_LRC_ERR;
               end else begin
                  out_in.frame_status = ST_OK;
               end
               out_in.is_exception = exc_flag;
               out_in.exception_code = exc_flag ? exc_ff : 8'd0;
               out_in.slave_address = addr_ff;
               out_in.function_code = func_ff;
               phase_in = PH_HUNT;
               count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         target_ff <= '0;
         high_ff <= '0;
         sum_ff <= '0;
         addr_ff <= '0;
         func_ff <= '0;
         exc_ff <= '0;
         lrc_ff <= '0;
         cr_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         target_ff <= target_in;
         high_ff <= high_in;
         sum_ff <= sum_in;
         addr_ff <= addr_in;
         func_ff <= func_in;
         exc_ff <= exc_in;
         lrc_ff <= lrc_in;
         cr_ff <= cr_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = emit;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance && emit) begin
         out_ff <= out_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'd0, out_ff};

endmodule

@@ hdl/mbar_checker.sv @@
// ----------------------------------------------------------------------------
// mbar_checker
// Port-level checks on the ASCII frame receiver, bound into the receiver module.
// ----------------------------------------------------------------------------
module mbar_checker
   import mbar_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   rsp_fields_type f;
   assign f = rsp_tdata[RSP_DATA_W-6:0];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_byte_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> f.frame_status == ST_OK && !f.is_exception
         && f.exception_code == 8'd0)
      else $error("status fields set on a data word");

   a_end_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> f.data_byte == 8'd0 && f.byte_index == 8'd0
         && f.frame_status <= ST_TRAILER && f.is_exception == f.function_code[7])
      else $error("malformed frame end word");

   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && f.byte_index == 8'd0 |-> f.function_code == 8'd0
         && f.slave_address == f.data_byte)
      else $error("address word carries stale header");

endmodule

bind modbus_ascii_frame_receiver mbar_checker u_mbar_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
